### rtl/core/bpt_pkg.sv
// Package for the best-partner tracker: sizes, constants and shared types.
// No dependencies; bpt_hist and the top level import it.
package bpt_pkg;

  localparam int unsigned NumMarkers = 4096;
  localparam int unsigned MarkerW    = 12;
  localparam int unsigned TopBucket  = 63;
  localparam int unsigned NumBuckets = TopBucket + 1;
  localparam int unsigned BucketW    = 6;
  localparam int unsigned Rollover   = 1024;
  localparam int unsigned TimerW     = 11;
  localparam int unsigned ScoreW     = 16;
  localparam int unsigned PartnerW   = 13;
  localparam int unsigned CountW     = 32;
  localparam int unsigned EntryW     = ScoreW + PartnerW;
  localparam int unsigned PaddrW     = 3;

  localparam logic [PartnerW-1:0] NoPartner = PartnerW'(NumMarkers);
  localparam logic [CountW-1:0]   CountMax  = '1;

  localparam logic [PaddrW-1:0] RegTopK        = 3'd0;
  localparam logic [PaddrW-1:0] RegCutoffStart = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REFRESH,
    ST_READ,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    HS_CLEAR,
    HS_IDLE,
    HS_READ,
    HS_WRITE
  } hist_state_e;

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] x,
                                                input logic [CountW-1:0] y);
    logic [CountW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

endpackage

### rtl/core/bpt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module bpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### rtl/core/bpt_hist.sv
// Score histogram and cumulative table, one RAM word per bucket (count above, sum below).
// Depends on bpt_pkg and bpt_ram. Refresh reads and writes each bucket from the top.
module bpt_hist import bpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               refresh_start_i,
  output logic               refresh_busy_o,
  input  logic [ScoreW-1:0]  cutoff_i,
  input  logic               bump_i,
  input  logic [BucketW-1:0] bucket_i,
  output logic [CountW-1:0]  count_o,
  output logic [CountW-1:0]  cumul_o
);

  hist_state_e         state_q, state_d;
  logic [BucketW-1:0]  idx_q, idx_d, idx_up;
  logic [CountW-1:0]   carry_q, carry_d, cumul_new;
  logic                carry_use;
  logic                ram_we;
  logic [BucketW-1:0]  ram_addr;
  logic [2*CountW-1:0] ram_wdata, ram_rdata;

  bpt_ram #(.Width(2 * CountW), .Depth(NumBuckets)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign refresh_busy_o = (state_q != HS_IDLE);
  // Valid in the cycle after bucket_i was presented while idle.
  assign count_o = sat_add(ram_rdata[2*CountW-1:CountW], CountW'(1));
  assign cumul_o = ram_rdata[CountW-1:0];

  // A bucket takes the running sum from above while the bucket above it lies over the cutoff.
  assign idx_up    = idx_q + 1'b1;
  assign carry_use = (idx_q != BucketW'(TopBucket)) && ({2'b0, idx_up, 8'd0} > cutoff_i);
  assign cumul_new = carry_use ? sat_add(ram_rdata[2*CountW-1:CountW], carry_q)
                               : ram_rdata[2*CountW-1:CountW];

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    carry_d   = carry_q;
    ram_we    = 1'b0;
    ram_addr  = bucket_i;
    ram_wdata = {count_o, cumul_o};
    case (state_q)
      HS_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q;
        ram_wdata = '0;
        idx_d     = idx_q + 1'b1;
        if (idx_q == BucketW'(TopBucket)) begin
          state_d = HS_IDLE;
        end
      end
      HS_IDLE: begin
        ram_we = bump_i;
        if (refresh_start_i) begin
          idx_d   = BucketW'(TopBucket);
          carry_d = '0;
          state_d = HS_READ;
        end
      end
      HS_READ: begin
        ram_addr = idx_q;
        state_d  = HS_WRITE;
      end
      HS_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q;
        ram_wdata = {ram_rdata[2*CountW-1:CountW], cumul_new};
        carry_d   = cumul_new;
        if (idx_q == '0) begin
          state_d = HS_IDLE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = HS_READ;
        end
      end
      default: state_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_CLEAR;
      idx_q   <= '0;
      carry_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      carry_q <= carry_d;
    end
  end

endmodule

### rtl/core/best_partner_tracker_adaptive_cutoff.sv
// Best-partner tracker with an adaptive score cutoff, top level.
// Depends on bpt_pkg, bpt_ram and bpt_hist.
//
// Each input word carries two marker indices and a Q8.8 pair score. The block
// keeps the best score and partner of every marker in one 4096-entry RAM and
// returns one output word per input word: an improvement flag, the cutoff and
// both markers' bests after the update. Histogram and cumulative table share a
// second, 64-entry RAM. Input words are accepted on in_valid_i with in_stall_o
// low; output words leave on out_valid_o and are held while out_stall_i is high.
// The output word passes the marker a, histogram, marker b and output register
// steps after acceptance; the next word is taken once it is registered, as the
// two read-modify-writes share one RAM port. After every 1024 words the
// cumulative table is rebuilt once the next word is offered: a read and a write
// per bucket hold that word off until the rebuild is done. After reset a
// clearing pass writes every marker entry, one a cycle (the histogram clears
// its 64 buckets meanwhile); no word is accepted then, but configuration writes
// are taken. A stalled receiver holds its output word; the block takes one more
// word and keeps its result until the held one leaves.
// Writing cutoff_start also reloads the running cutoff.
module best_partner_tracker_adaptive_cutoff import bpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MarkerW-1:0]  marker_a_i,
  input  logic [MarkerW-1:0]  marker_b_i,
  input  logic [ScoreW-1:0]   pair_score_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                improved_o,
  output logic [ScoreW-1:0]   cutoff_now_o,
  output logic [ScoreW-1:0]   best_score_a_o,
  output logic [PartnerW-1:0] best_partner_a_o,
  output logic [ScoreW-1:0]   best_score_b_o,
  output logic [PartnerW-1:0] best_partner_b_o
);

  state_e state_q, state_d;

  logic [ScoreW-1:0]  top_k_q, cutoff_start_q, cutoff_q, cutoff_d;
  logic [TimerW-1:0]  timer_q, timer_d;
  logic [MarkerW-1:0] a_q, b_q, clr_q, clr_d;
  logic [ScoreW-1:0]  score_q;
  logic [ScoreW-1:0]  sa_q, sa_d, sb_q, sb_d;
  logic [PartnerW-1:0] pa_q, pa_d, pb_q, pb_d;
  logic               imp_q, imp_d, out_valid_q, out_valid_d;
  logic               cfg_wr, accept;

  // RAM port and histogram signals.
  logic                ram_we;
  logic [MarkerW-1:0]  ram_addr;
  logic [EntryW-1:0]   ram_wdata, ram_rdata;
  logic                ref_start, ref_busy, bump;
  logic [BucketW-1:0]  bucket;
  logic [CountW-1:0]   cnt_new, cumul;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr)
      RegTopK:        prdata = {16'd0, top_k_q};
      RegCutoffStart: prdata = {16'd0, cutoff_start_q};
      default:        prdata = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE) || (timer_q >= TimerW'(Rollover));
  assign accept     = in_valid_i && !in_stall_o;

  // Histogram bucket: integer part of the score, clamped to the top bucket.
  assign bucket = (score_q[15:8] > 8'(TopBucket)) ? BucketW'(TopBucket)
                                                  : score_q[BucketW+7:8];

  bpt_ram #(.Width(EntryW), .Depth(NumMarkers)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  bpt_hist u_hist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .refresh_start_i(ref_start),
    .refresh_busy_o (ref_busy),
    .cutoff_i       (cutoff_q),
    .bump_i         (bump),
    .bucket_i       (bucket),
    .count_o        (cnt_new),
    .cumul_o        (cumul)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    timer_d     = timer_q;
    cutoff_d    = cutoff_q;
    sa_d        = sa_q;
    pa_d        = pa_q;
    sb_d        = sb_q;
    pb_d        = pb_q;
    imp_d       = imp_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_addr    = a_q;
    ram_wdata   = '0;
    ref_start   = 1'b0;
    bump        = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = {ScoreW'(0), NoPartner};
        clr_d     = clr_q + 1'b1;
        if (clr_q == MarkerW'(NumMarkers - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = marker_a_i;
        if (timer_q >= TimerW'(Rollover)) begin
          // The rebuild waits for the next word so it sees the cutoff that word sees.
          if (in_valid_i) begin
            ref_start = 1'b1;
            timer_d   = '0;
            state_d   = ST_REFRESH;
          end
        end else if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_REFRESH: begin
        if (!ref_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        // Entry of marker a arrives; the histogram entry is read meanwhile.
        ram_addr = a_q;
        sa_d     = ram_rdata[EntryW-1:PartnerW];
        pa_d     = ram_rdata[PartnerW-1:0];
        imp_d    = 1'b0;
        if (score_q > ram_rdata[EntryW-1:PartnerW]) begin
          sa_d     = score_q;
          pa_d     = {1'b0, b_q};
          imp_d    = 1'b1;
          ram_we   = 1'b1;
          ram_wdata = {score_q, 1'b0, b_q};
        end
        state_d = ST_WRITE_A;
      end
      ST_WRITE_A: begin
        // Histogram entry is here; update it and the cutoff.
        if (score_q > cutoff_q) begin
          bump = 1'b1;
          if ((cnt_new >= CountW'(top_k_q)) || (cumul >= CountW'(top_k_q))) begin
            cutoff_d = {2'b0, bucket, 8'd0};
          end
        end
        // Issue the read of marker b after a's write has landed.
        ram_addr = b_q;
        state_d  = ST_WRITE_B;
      end
      ST_WRITE_B: begin
        ram_addr = b_q;
        sb_d     = ram_rdata[EntryW-1:PartnerW];
        pb_d     = ram_rdata[PartnerW-1:0];
        if (score_q > ram_rdata[EntryW-1:PartnerW]) begin
          sb_d      = score_q;
          pb_d      = {1'b0, a_q};
          imp_d     = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = {score_q, 1'b0, a_q};
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          timer_d     = timer_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Same marker twice: b sees a's result.
    if (state_q == ST_WRITE_B && a_q == b_q) begin
      sb_d = sa_q;
      pb_d = pa_q;
    end
    if (state_q == ST_WRITE_B && a_q == b_q) begin
      ram_we = 1'b0;
      imp_d  = imp_q;
    end
    if (cfg_wr && paddr == RegCutoffStart) begin
      cutoff_d = pwdata[ScoreW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      timer_q        <= '0;
      top_k_q        <= 16'd100;
      cutoff_start_q <= '0;
      cutoff_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      timer_q     <= timer_d;
      cutoff_q    <= cutoff_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && paddr == RegTopK) begin
        top_k_q <= pwdata[ScoreW-1:0];
      end
      if (cfg_wr && paddr == RegCutoffStart) begin
        cutoff_start_q <= pwdata[ScoreW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q     <= marker_a_i;
      b_q     <= marker_b_i;
      score_q <= pair_score_i;
    end
    sa_q  <= sa_d;
    pa_q  <= pa_d;
    sb_q  <= sb_d;
    pb_q  <= pb_d;
    imp_q <= imp_d;
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      improved_o       <= imp_q;
      cutoff_now_o     <= cutoff_q;
      best_score_a_o   <= sa_q;
      best_partner_a_o <= pa_q;
      best_score_b_o   <= sb_q;
      best_partner_b_o <= pb_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A held output word stays valid and its marker-a best score does not change under a stall.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(best_score_a_o))
    else $error("output word changed under stall");

  // No word is accepted while the table refresh or RAM clearing runs.
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFRESH || state_q == ST_CLEAR) |-> in_stall_o)
    else $error("word accepted during maintenance");

  // An improving word reports a best score equal to its own score.
  a_imp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && improved_o |->
      (best_score_a_o == score_q) || (best_score_b_o == score_q))
    else $error("improvement without matching best score");

endmodule
